// ===== rtl/fcl_pkg.sv =====
// ----------------------------------------------------------------------------
// fcl_pkg
// shared constants, arctangent table and helpers for the friction cone unit
// ----------------------------------------------------------------------------
`default_nettype none

package fcl_pkg;

    localparam int MAX_SIDES_DEF  = 62;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int ROT_W   = 16;
    localparam int SIDES_W = 6;
    localparam int ROW_W   = 6;
    localparam int COMP_W  = 24;
    localparam int MU_W    = 16;
    localparam int TRIG_W  = 19;
    localparam int PROD_W  = 41;
    localparam int ACC_W   = 42;
    localparam int DIVISOR_W = 7;

    localparam logic [MU_W-1:0] MU_RESET = 16'd4096;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_XY_W  = 34;
    localparam int CORDIC_Z_W   = 33;
    localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [COMP_W-1:0] UNIT_Q16 = 24'sd65536;
    localparam logic signed [COMP_W-1:0] OUT_MAX  = 24'sd8388607;
    localparam logic signed [COMP_W-1:0] OUT_MIN  = -24'sd8388608;

    function automatic logic signed [CORDIC_Z_W-1:0] atan_turns(input logic [4:0] k);
        logic signed [CORDIC_Z_W-1:0] a;
        case (k)
            5'd0:  a = 33'sd536870912;
            5'd1:  a = 33'sd316933406;
            5'd2:  a = 33'sd167458907;
            5'd3:  a = 33'sd85004756;
            5'd4:  a = 33'sd42667331;
            5'd5:  a = 33'sd21354465;
            5'd6:  a = 33'sd10679838;
            5'd7:  a = 33'sd5340245;
            5'd8:  a = 33'sd2670163;
            5'd9:  a = 33'sd1335087;
            5'd10: a = 33'sd667544;
            5'd11: a = 33'sd333772;
            5'd12: a = 33'sd166886;
            5'd13: a = 33'sd83443;
            5'd14: a = 33'sd41722;
            5'd15: a = 33'sd20861;
            5'd16: a = 33'sd10430;
            5'd17: a = 33'sd5215;
            5'd18: a = 33'sd2608;
            5'd19: a = 33'sd1304;
            5'd20: a = 33'sd652;
            5'd21: a = 33'sd326;
            5'd22: a = 33'sd163;
            5'd23: a = 33'sd81;
            5'd24: a = 33'sd41;
            5'd25: a = 33'sd20;
            5'd26: a = 33'sd10;
            5'd27: a = 33'sd5;
            5'd28: a = 33'sd3;
            5'd29: a = 33'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // component of a matrix-vector term, row-major term order
    function automatic logic [1:0] term_comp(input logic [3:0] j);
        logic [1:0] c;
        case (j)
            4'd0, 4'd1, 4'd2: c = 2'd0;
            4'd3, 4'd4, 4'd5: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] term_col(input logic [3:0] j);
        logic [1:0] c;
        case (j)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fcl_div.sv =====
// ----------------------------------------------------------------------------
// fcl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_div #(
    parameter int W = fcl_pkg::ANGLE_BITS_DEF + 7
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [W-1:0]                   dividend,
    input  wire logic [fcl_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                done,
    output logic [W-1:0]                        quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]                  work_reg;
    logic [fcl_pkg::DIVISOR_W-1:0] rem_reg;
    logic [fcl_pkg::DIVISOR_W-1:0] dsr_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [fcl_pkg::DIVISOR_W:0]   trial;
    logic                          fits;

    assign trial    = {rem_reg, work_reg[W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            work_reg <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                work_reg <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (fits)
                    rem_reg <= fcl_pkg::DIVISOR_W'(trial - {1'b0, dsr_reg});
                else
                    rem_reg <= trial[fcl_pkg::DIVISOR_W-1:0];
                work_reg <= {work_reg[W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcl_cordic.sv =====
// ----------------------------------------------------------------------------
// fcl_cordic
// iterative rotation cordic, cosine and sine of a 32-bit turn angle in q16
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_cordic (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [31:0]                       angle,
    output logic                                   done,
    output logic signed [fcl_pkg::TRIG_W-1:0]      cos_q16,
    output logic signed [fcl_pkg::TRIG_W-1:0]      sin_q16
);

    localparam int XW = fcl_pkg::CORDIC_XY_W;
    localparam int ZW = fcl_pkg::CORDIC_Z_W;

    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [1:0]           quad_reg;
    logic [4:0]           k_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    logic signed [fcl_pkg::TRIG_W-1:0] c;
    logic signed [fcl_pkg::TRIG_W-1:0] s;

    assign dx = y_reg >>> k_reg;
    assign dy = x_reg >>> k_reg;
    assign xr = (x_reg + XW'(8192)) >>> 14;
    assign yr = (y_reg + XW'(8192)) >>> 14;
    assign c  = xr[fcl_pkg::TRIG_W-1:0];
    assign s  = yr[fcl_pkg::TRIG_W-1:0];
    assign done = done_reg;

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_q16 = c;
                sin_q16 = s;
            end
            2'd1:
            begin
                cos_q16 = -s;
                sin_q16 = c;
            end
            2'd2:
            begin
                cos_q16 = -c;
                sin_q16 = -s;
            end
            default:
            begin
                cos_q16 = s;
                sin_q16 = -c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            quad_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
                x_reg    <= fcl_pkg::CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= ZW'({2'b00, angle[29:0]});
                quad_reg <= angle[31:30];
            end
            else if (busy_reg)
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - fcl_pkg::atan_turns(k_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + fcl_pkg::atan_turns(k_reg);
                end
                k_reg <= k_reg + 1'b1;
                if (k_reg == 5'(fcl_pkg::CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/friction_cone_linearizer_unit.sv =====
// ----------------------------------------------------------------------------
// friction_cone_linearizer_unit
// linearised friction cone generator, one constraint row per output word
// ----------------------------------------------------------------------------
// One input word (rotation matrix and side count N, clamped to MAX_SIDES)
// yields N+2 output words. The unit takes no new word until the last row of
// the current one is loaded into the output register. Cost per request is
// set by a restoring divider, a 30-step cordic and one shared multiplier
// used for nine terms per row: the cone set-up when N is not zero uses all
// three, each normal row uses the multiplier only, each side row uses all
// three, and any output stall adds to the cost.
`default_nettype none

module friction_cone_linearizer_unit #(
    parameter int MAX_SIDES  = fcl_pkg::MAX_SIDES_DEF,
    parameter int ANGLE_BITS = fcl_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // friction_coef
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [151:0] s_axis_tdata, // rot_00..rot_22, sides, zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // row_index, comp_x, comp_y, comp_z, zero fill
    output logic             m_axis_tlast   // last_row
);

    localparam int DW = ANGLE_BITS + 7;
    localparam int RW = fcl_pkg::ROT_W;
    localparam int VW = fcl_pkg::COMP_W;
    localparam int AW = fcl_pkg::ACC_W;
    localparam int PW = fcl_pkg::PROD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_HDIV, S_HCOR, S_WMUL, S_WACC, S_ROW, S_PDIV, S_PCOR, S_MAC, S_EMIT
    } state_t;

    state_t state_reg;
    logic [fcl_pkg::MU_W-1:0]    mu_reg;
    logic signed [RW-1:0]        rot_reg [9];
    logic [fcl_pkg::SIDES_W-1:0] n_reg;
    logic [fcl_pkg::ROW_W-1:0]   row_reg;
    logic signed [fcl_pkg::TRIG_W-1:0] ch_reg;
    logic signed [VW-1:0]        w_reg;
    logic signed [VW-1:0]        vec_reg [3];
    logic signed [AW-1:0]        acc_reg [3];
    logic signed [PW-1:0]        prod_reg;
    logic [3:0]                  mac_reg;
    logic                        div_start_reg;
    logic                        cor_start_reg;
    logic [DW-1:0]               div_dividend_reg;
    logic                        out_valid_reg;
    logic [79:0]                 out_data_reg;
    logic                        out_last_reg;

    logic                        div_done;
    logic [DW-1:0]               div_q;
    logic                        cor_done;
    logic signed [fcl_pkg::TRIG_W-1:0] cor_c;
    logic signed [fcl_pkg::TRIG_W-1:0] cor_s;
    logic [31:0]                 cor_angle;
    logic [3:0]                  sel;
    logic signed [16:0]          mul_a;
    logic signed [VW-1:0]        mul_b;
    logic signed [PW-1:0]        mul_p;
    logic [fcl_pkg::SIDES_W-1:0] in_sides;
    logic [fcl_pkg::SIDES_W-1:0] n_clamped;
    logic [fcl_pkg::ROW_W-1:0]   side_idx;
    logic                        is_last;
    logic signed [VW-1:0]        sat_x;
    logic signed [VW-1:0]        sat_y;
    logic signed [VW-1:0]        sat_z;
    logic signed [PW-1:0]        w_round;

    function automatic logic signed [VW-1:0] sat_out(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] v;
        v = (a + AW'(8192)) >>> 14;
        if (v > AW'(fcl_pkg::OUT_MAX))
            return fcl_pkg::OUT_MAX;
        else if (v < AW'(fcl_pkg::OUT_MIN))
            return fcl_pkg::OUT_MIN;
        else
            return v[VW-1:0];
    endfunction

    fcl_div #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  ({n_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cor_angle = {div_q[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};

    fcl_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start_reg),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_q16 (cor_c),
        .sin_q16 (cor_s)
    );

    assign in_sides  = s_axis_tdata[149:144];
    assign n_clamped = (in_sides > fcl_pkg::SIDES_W'(MAX_SIDES))
                       ? fcl_pkg::SIDES_W'(MAX_SIDES) : in_sides;
    assign side_idx  = row_reg - 2'd2;
    assign is_last   = (n_reg == '0) ? (row_reg == fcl_pkg::ROW_W'(1))
                                     : (row_reg == n_reg + 2'd1);

    assign sel = (mac_reg > 4'd8) ? 4'd8 : mac_reg;

    always_comb
    begin
        if (state_reg == S_WMUL)
        begin
            mul_a = {1'b0, mu_reg};
            mul_b = VW'(ch_reg);
        end
        else
        begin
            mul_a = 17'(rot_reg[sel]);
            mul_b = vec_reg[fcl_pkg::term_col(sel)];
        end
    end

    assign mul_p   = PW'(mul_a) * PW'(mul_b);
    assign w_round = (prod_reg + PW'(2048)) >>> 12;
    assign sat_x   = sat_out(acc_reg[0]);
    assign sat_y   = sat_out(acc_reg[1]);
    assign sat_z   = sat_out(acc_reg[2]);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg <= fcl_pkg::MU_RESET;
        end
        else if (cfg_wr_en)
        begin
            mu_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            n_reg            <= '0;
            row_reg          <= '0;
            ch_reg           <= '0;
            w_reg            <= '0;
            prod_reg         <= '0;
            mac_reg          <= '0;
            div_start_reg    <= 1'b0;
            cor_start_reg    <= 1'b0;
            div_dividend_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            out_last_reg     <= 1'b0;
            for (int k = 0; k < 9; k++)
                rot_reg[k] <= '0;
            for (int k = 0; k < 3; k++)
            begin
                vec_reg[k] <= '0;
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            if (out_valid_reg && m_axis_tready && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        for (int k = 0; k < 9; k++)
                            rot_reg[k] <= s_axis_tdata[k*RW +: RW];
                        n_reg   <= n_clamped;
                        row_reg <= '0;
                        if (n_clamped == '0)
                            state_reg <= S_ROW;
                        else
                        begin
                            div_dividend_reg <= DW'((1 << ANGLE_BITS)) + DW'(n_clamped);
                            div_start_reg    <= 1'b1;
                            state_reg        <= S_HDIV;
                        end
                    end
                end
                S_HDIV:
                begin
                    if (div_done)
                    begin
                        cor_start_reg <= 1'b1;
                        state_reg     <= S_HCOR;
                    end
                end
                S_HCOR:
                begin
                    if (cor_done)
                    begin
                        ch_reg    <= cor_c;
                        state_reg <= S_WMUL;
                    end
                end
                S_WMUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_WACC;
                end
                S_WACC:
                begin
                    w_reg     <= -VW'(w_round);
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    mac_reg <= '0;
                    for (int k = 0; k < 3; k++)
                        acc_reg[k] <= '0;
                    if (row_reg == '0)
                    begin
                        vec_reg[0] <= '0;
                        vec_reg[1] <= '0;
                        vec_reg[2] <= fcl_pkg::UNIT_Q16;
                        state_reg  <= S_MAC;
                    end
                    else if (row_reg == fcl_pkg::ROW_W'(1))
                    begin
                        vec_reg[0] <= '0;
                        vec_reg[1] <= '0;
                        vec_reg[2] <= -fcl_pkg::UNIT_Q16;
                        state_reg  <= S_MAC;
                    end
                    else
                    begin
                        div_dividend_reg <= {side_idx, {(ANGLE_BITS + 1){1'b0}}}
                                            + DW'(n_reg);
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_PDIV;
                    end
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        cor_start_reg <= 1'b1;
                        state_reg     <= S_PCOR;
                    end
                end
                S_PCOR:
                begin
                    if (cor_done)
                    begin
                        vec_reg[0] <= VW'(cor_c);
                        vec_reg[1] <= VW'(cor_s);
                        vec_reg[2] <= w_reg;
                        state_reg  <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (mac_reg < 4'd9)
                        prod_reg <= mul_p;
                    if (mac_reg != '0)
                        acc_reg[fcl_pkg::term_comp(mac_reg - 1'b1)] <=
                            acc_reg[fcl_pkg::term_comp(mac_reg - 1'b1)] + AW'(prod_reg);
                    if (mac_reg == 4'd9)
                        state_reg <= S_EMIT;
                    else
                        mac_reg <= mac_reg + 1'b1;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, sat_z, sat_y, sat_x, row_reg};
                        out_last_reg  <= is_last;
                        if (is_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= S_ROW;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
